>>> rtl/bfid_pkg.sv
package bfid_pkg;

  localparam int MAX_DEST_WIDTH_DEF   = 1024;
  localparam int MAX_SOURCE_WIDTH_DEF = 4096;
  localparam int SRC_H_LIMIT          = 4096;
  localparam int DST_H_LIMIT          = 1024;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 40;
  localparam int ASUM_W     = 32;
  localparam int CNT_W      = 25;
  localparam int SROW_W     = 12;
  localparam int SH_W       = 13;
  localparam int DH_W       = 11;
  localparam int DROW_W     = 10;
  localparam int OUT_POS_W  = 10;
  localparam int RFRAC_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SW_CFG_W   = 13;
  localparam int DW_CFG_W   = 11;
  localparam int OUT_DIV_Q  = 8;

  localparam logic [PIX_W-1:0] OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_ALPHA_EN   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_RED   = 2'd0,
    OP_GREEN = 2'd1,
    OP_BLUE  = 2'd2,
    OP_ALPHA = 2'd3
  } op_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ACC   = 6'b000100,
    S_DIV   = 6'b001000,
    S_OUT   = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

  typedef struct packed {
    logic [SUM_W-1:0]  red;
    logic [SUM_W-1:0]  green;
    logic [SUM_W-1:0]  blue;
    logic [ASUM_W-1:0] alpha;
    logic [CNT_W-1:0]  count;
  } acc_t;

endpackage

>>> rtl/box_filter_image_downscaler_core.sv
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// pixel    in         in_valid_i/in_ready_o   in_red_i, in_green_i, in_blue_i, in_alpha_i
// result   out        out_valid_o/out_ready_i out_row_o .. out_alpha_o, image_done_o
//
// A pixel that does not close a block is accepted with the sum memory read, then the
// read-modify-write follows. A pixel that closes a block then runs up to four divisions
// in one shared divider, one per channel, passes a channel that needs none with no
// division, then loads the output register.
// After reset and after every write to register index 0 to 4 a clearing pass zeroes
// the sums and derives the block steps; no pixel is taken then.
// A full output register stalls only the next finished block.
module box_filter_image_downscaler_core #(
  parameter int MAX_DEST_WIDTH   = bfid_pkg::MAX_DEST_WIDTH_DEF,
  parameter int MAX_SOURCE_WIDTH = bfid_pkg::MAX_SOURCE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bfid_pkg::PIX_W-1:0]      in_red_i,
  input  logic [bfid_pkg::PIX_W-1:0]      in_green_i,
  input  logic [bfid_pkg::PIX_W-1:0]      in_blue_i,
  input  logic [bfid_pkg::PIX_W-1:0]      in_alpha_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bfid_pkg::OUT_POS_W-1:0]  out_row_o,
  output logic [bfid_pkg::OUT_POS_W-1:0]  out_column_o,
  output logic [bfid_pkg::PIX_W-1:0]      out_red_o,
  output logic [bfid_pkg::PIX_W-1:0]      out_green_o,
  output logic [bfid_pkg::PIX_W-1:0]      out_blue_o,
  output logic [bfid_pkg::PIX_W-1:0]      out_alpha_o,
  output logic                            image_done_o
);

  localparam int SWW = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int DWW = $clog2(MAX_DEST_WIDTH + 1);
  localparam int AW  = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
  localparam int CFW = DWW + 2;
  localparam int RFW = bfid_pkg::RFRAC_W;

  function automatic int clamp_size(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Configuration registers.
  logic [bfid_pkg::SW_CFG_W-1:0] cfg_sw_q, cfg_sh_q;
  logic [bfid_pkg::DW_CFG_W-1:0] cfg_dw_q, cfg_dh_q;
  logic                          alpha_en_q;
  logic                          cfg_we, restart;

  logic [SWW-1:0]                 sw;
  logic [bfid_pkg::SH_W-1:0]      sh;
  logic [DWW-1:0]                 dw;
  logic [bfid_pkg::DH_W-1:0]      dh;

  always_comb begin
    int swi, shi, dwi, dhi;
    swi = clamp_size(int'(cfg_sw_q), MAX_SOURCE_WIDTH);
    shi = clamp_size(int'(cfg_sh_q), bfid_pkg::SRC_H_LIMIT);
    dwi = clamp_size(int'(cfg_dw_q), MAX_DEST_WIDTH);
    dhi = clamp_size(int'(cfg_dh_q), bfid_pkg::DST_H_LIMIT);
    if (dwi > swi) dwi = swi;
    if (dhi > shi) dhi = shi;
    sw = SWW'(swi);
    sh = bfid_pkg::SH_W'(shi);
    dw = DWW'(dwi);
    dh = bfid_pkg::DH_W'(dhi);
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && (cfg_index_i <= bfid_pkg::CFG_ALPHA_EN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sw_q   <= bfid_pkg::SW_CFG_W'(1);
      cfg_sh_q   <= bfid_pkg::SW_CFG_W'(1);
      cfg_dw_q   <= bfid_pkg::DW_CFG_W'(1);
      cfg_dh_q   <= bfid_pkg::DW_CFG_W'(1);
      alpha_en_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        bfid_pkg::CFG_SRC_WIDTH:  cfg_sw_q   <= cfg_data_i;
        bfid_pkg::CFG_SRC_HEIGHT: cfg_sh_q   <= cfg_data_i;
        bfid_pkg::CFG_DST_WIDTH:  cfg_dw_q   <= cfg_data_i[bfid_pkg::DW_CFG_W-1:0];
        bfid_pkg::CFG_DST_HEIGHT: cfg_dh_q   <= cfg_data_i[bfid_pkg::DW_CFG_W-1:0];
        bfid_pkg::CFG_ALPHA_EN:   alpha_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Block step dividers, run during the clearing pass.
  logic                          geo_start_q;
  logic                          geo_w_done, geo_h_done, geo_w_ok_q, geo_h_ok_q;
  logic [SWW-1:0]                qw;
  logic [DWW-1:0]                rw;
  logic [bfid_pkg::SH_W-1:0]     qh;
  logic [bfid_pkg::DH_W-1:0]     rh;

  bfid_div #(.N_W(SWW), .D_W(DWW), .Q_W(SWW)) u_geo_w (
    .clk_i, .rst_ni,
    .start_i(geo_start_q), .dividend_i(sw), .divisor_i(dw),
    .done_o(geo_w_done), .quotient_o(qw), .remainder_o(rw)
  );

  bfid_div #(.N_W(bfid_pkg::SH_W), .D_W(bfid_pkg::DH_W), .Q_W(bfid_pkg::SH_W)) u_geo_h (
    .clk_i, .rst_ni,
    .start_i(geo_start_q), .dividend_i(sh), .divisor_i(dh),
    .done_o(geo_h_done), .quotient_o(qh), .remainder_o(rh)
  );

  // Control and position state.
  bfid_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_addr_q;
  logic             swept_q;

  logic [SWW-1:0]                src_col_q, cend_q;
  logic [bfid_pkg::SROW_W-1:0]   src_row_q;
  logic [bfid_pkg::SH_W-1:0]     rend_q;
  logic signed [CFW-1:0]         cfrac_q;
  logic signed [RFW-1:0]         rfrac_q;
  logic [AW-1:0]                 dcol_q;
  logic [bfid_pkg::DROW_W-1:0]   drow_q;

  logic [SWW-1:0]                p_col, n_col, c_base, c_e, n_cend;
  logic [bfid_pkg::SROW_W-1:0]   p_row, n_row;
  logic [bfid_pkg::SH_W-1:0]     r_base, r_e, n_rend;
  logic signed [CFW-1:0]         c_fbase, c_f, n_cfrac;
  logic signed [RFW-1:0]         r_fbase, r_f, n_rfrac;
  logic [AW-1:0]                 n_dcol;
  logic [bfid_pkg::DROW_W-1:0]   n_drow;
  logic                          c_step, r_step, n_last, n_done;
  logic                          in_acc;

  assign in_ready_o = (state_q == bfid_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    logic [SWW:0]             col_inc;
    logic [bfid_pkg::SH_W-1:0] row_inc;
    p_col = src_col_q;
    p_row = src_row_q;
    if (p_col >= sw || {1'b0, p_row} >= sh) begin
      p_col = '0;
      p_row = '0;
    end
    n_cend  = cend_q;
    n_cfrac = cfrac_q;
    n_dcol  = dcol_q;
    n_rend  = rend_q;
    n_rfrac = rfrac_q;
    n_drow  = drow_q;
    c_step  = 1'b0;
    r_step  = 1'b0;
    c_base  = cend_q;
    c_fbase = cfrac_q;
    r_base  = rend_q;
    r_fbase = rfrac_q;
    if (p_col == '0) begin
      c_step  = 1'b1;
      c_base  = '0;
      c_fbase = -$signed(CFW'(dw >> 1));
      n_dcol  = '0;
      if (p_row == '0) begin
        r_step  = 1'b1;
        r_base  = '0;
        r_fbase = -$signed(RFW'(dh >> 1));
        n_drow  = '0;
      end else if ({1'b0, p_row} == rend_q) begin
        r_step = 1'b1;
        n_drow = drow_q + 1'b1;
      end
    end else if (p_col == cend_q) begin
      c_step = 1'b1;
      n_dcol = dcol_q + 1'b1;
    end
    c_f = c_fbase + $signed(CFW'(rw));
    c_e = c_base + qw;
    if (c_f > 0) begin
      c_e = c_e + 1'b1;
      c_f = c_f - $signed(CFW'(dw));
    end
    r_f = r_fbase + $signed(RFW'(rh));
    r_e = r_base + qh;
    if (r_f > 0) begin
      r_e = r_e + 1'b1;
      r_f = r_f - $signed(RFW'(dh));
    end
    if (c_step) begin
      n_cend  = c_e;
      n_cfrac = c_f;
    end
    if (r_step) begin
      n_rend  = r_e;
      n_rfrac = r_f;
    end
    n_last = ({1'b0, p_col} + 1'b1 == {1'b0, n_cend})
          && ({1'b0, p_row} + 1'b1 == n_rend);
    n_done = ({1'b0, n_drow} + 1'b1 == dh)
          && ((DWW + 1)'(n_dcol) + 1'b1 == (DWW + 1)'(dw));
    col_inc = {1'b0, p_col} + 1'b1;
    row_inc = {1'b0, p_row} + 1'b1;
    n_col   = col_inc[SWW-1:0];
    n_row   = p_row;
    if (col_inc >= {1'b0, sw}) begin
      n_col = '0;
      n_row = (row_inc >= sh) ? '0 : row_inc[bfid_pkg::SROW_W-1:0];
    end
  end

  // Per-pixel payload held for the read-modify-write.
  logic [bfid_pkg::PIX_W-1:0]   pr_q, pg_q, pb_q, pa_q;
  logic [AW-1:0]                idx_q;
  logic                         last_q, done_q;
  logic [bfid_pkg::DROW_W-1:0]  orow_q;

  bfid_pkg::acc_t mem_rdata, mem_wdata, acc_new, hold_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;

  bfid_mem #(.DEPTH(MAX_DEST_WIDTH), .AW(AW)) u_mem (
    .clk_i,
    .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .re_i(in_acc), .raddr_i(n_dcol), .rdata_o(mem_rdata)
  );

  always_comb begin
    logic [2*bfid_pkg::PIX_W-1:0] mr, mg, mb;
    mr = alpha_en_q ? pa_q * pr_q : (2*bfid_pkg::PIX_W)'(pr_q);
    mg = alpha_en_q ? pa_q * pg_q : (2*bfid_pkg::PIX_W)'(pg_q);
    mb = alpha_en_q ? pa_q * pb_q : (2*bfid_pkg::PIX_W)'(pb_q);
    acc_new.red   = mem_rdata.red + bfid_pkg::SUM_W'(mr);
    acc_new.green = mem_rdata.green + bfid_pkg::SUM_W'(mg);
    acc_new.blue  = mem_rdata.blue + bfid_pkg::SUM_W'(mb);
    acc_new.alpha = alpha_en_q ? mem_rdata.alpha + bfid_pkg::ASUM_W'(pa_q) : mem_rdata.alpha;
    acc_new.count = mem_rdata.count + 1'b1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = last_q ? '0 : acc_new;
    if (state_q == bfid_pkg::S_CLEAR) begin
      mem_we    = !swept_q;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (state_q == bfid_pkg::S_ACC) begin
      mem_we = 1'b1;
    end
  end

  // Output divisions through one shared divider.
  bfid_pkg::op_e               op_q;
  logic                        run_q, div_start, div_done, skip;
  logic [bfid_pkg::SUM_W-1:0]  div_num;
  logic [bfid_pkg::ASUM_W-1:0] div_den;
  logic [bfid_pkg::PIX_W-1:0]  div_q, skip_val;
  logic [bfid_pkg::ASUM_W-1:0] div_rem;
  logic [bfid_pkg::PIX_W-1:0]  res_r_q, res_g_q, res_b_q, res_a_q, res_val;
  logic                        res_we;

  always_comb begin
    case (op_q)
      bfid_pkg::OP_RED:   div_num = hold_q.red;
      bfid_pkg::OP_GREEN: div_num = hold_q.green;
      bfid_pkg::OP_BLUE:  div_num = hold_q.blue;
      default:            div_num = bfid_pkg::SUM_W'(hold_q.alpha);
    endcase
    div_den  = (alpha_en_q && op_q != bfid_pkg::OP_ALPHA) ? hold_q.alpha
             : bfid_pkg::ASUM_W'(hold_q.count);
    skip     = (alpha_en_q && hold_q.alpha == '0)
            || (!alpha_en_q && op_q == bfid_pkg::OP_ALPHA);
    skip_val = alpha_en_q ? '0 : bfid_pkg::OPAQUE;
    div_start = (state_q == bfid_pkg::S_DIV) && !run_q && !skip;
    res_we    = (state_q == bfid_pkg::S_DIV) && ((!run_q && skip) || (run_q && div_done));
    res_val   = run_q ? div_q : skip_val;
  end

  bfid_div #(.N_W(bfid_pkg::SUM_W), .D_W(bfid_pkg::ASUM_W), .Q_W(bfid_pkg::OUT_DIV_Q)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_num), .divisor_i(div_den),
    .done_o(div_done), .quotient_o(div_q), .remainder_o(div_rem)
  );

  logic load_out;
  assign load_out = (state_q == bfid_pkg::S_OUT) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfid_pkg::S_CLEAR: begin
        if (swept_q && geo_w_ok_q && geo_h_ok_q) state_d = bfid_pkg::S_IDLE;
      end
      bfid_pkg::S_IDLE: begin
        if (in_acc) state_d = bfid_pkg::S_ACC;
      end
      bfid_pkg::S_ACC: begin
        state_d = last_q ? bfid_pkg::S_DIV : bfid_pkg::S_IDLE;
      end
      bfid_pkg::S_DIV: begin
        if (res_we && op_q == bfid_pkg::OP_ALPHA) state_d = bfid_pkg::S_OUT;
      end
      bfid_pkg::S_OUT: begin
        if (load_out) state_d = bfid_pkg::S_IDLE;
      end
      default: state_d = bfid_pkg::S_CLEAR;
    endcase
    if (restart) state_d = bfid_pkg::S_CLEAR;
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfid_pkg::S_CLEAR;
      clr_addr_q  <= '0;
      swept_q     <= 1'b0;
      geo_start_q <= 1'b1;
      geo_w_ok_q  <= 1'b0;
      geo_h_ok_q  <= 1'b0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      cend_q      <= '0;
      rend_q      <= '0;
      cfrac_q     <= '0;
      rfrac_q     <= '0;
      dcol_q      <= '0;
      drow_q      <= '0;
      op_q        <= bfid_pkg::OP_RED;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      geo_start_q <= restart;
      if (restart) begin
        clr_addr_q <= '0;
        swept_q    <= 1'b0;
        geo_w_ok_q <= 1'b0;
        geo_h_ok_q <= 1'b0;
        src_col_q  <= '0;
        src_row_q  <= '0;
        cend_q     <= '0;
        rend_q     <= '0;
        cfrac_q    <= '0;
        rfrac_q    <= '0;
        dcol_q     <= '0;
        drow_q     <= '0;
      end else begin
        if (state_q == bfid_pkg::S_CLEAR && !swept_q) begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(MAX_DEST_WIDTH - 1)) swept_q <= 1'b1;
        end
        if (geo_w_done) geo_w_ok_q <= 1'b1;
        if (geo_h_done) geo_h_ok_q <= 1'b1;
        if (in_acc) begin
          src_col_q <= n_col;
          src_row_q <= n_row;
          cend_q    <= n_cend;
          rend_q    <= n_rend;
          cfrac_q   <= n_cfrac;
          rfrac_q   <= n_rfrac;
          dcol_q    <= n_dcol;
          drow_q    <= n_drow;
        end
      end
      if (state_q == bfid_pkg::S_ACC) begin
        op_q  <= bfid_pkg::OP_RED;
        run_q <= 1'b0;
      end else if (div_start) begin
        run_q <= 1'b1;
      end else if (res_we) begin
        run_q <= 1'b0;
        op_q  <= bfid_pkg::op_e'(op_q + 1'b1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [AW-1:0] ocol_q;
  logic          odone_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pr_q   <= in_red_i;
      pg_q   <= in_green_i;
      pb_q   <= in_blue_i;
      pa_q   <= in_alpha_i;
      idx_q  <= n_dcol;
      last_q <= n_last;
      done_q <= n_done;
      orow_q <= n_drow;
    end
    if (state_q == bfid_pkg::S_ACC && last_q) begin
      hold_q  <= acc_new;
      ocol_q  <= idx_q;
      odone_q <= done_q;
    end
    if (res_we) begin
      case (op_q)
        bfid_pkg::OP_RED:   res_r_q <= res_val;
        bfid_pkg::OP_GREEN: res_g_q <= res_val;
        bfid_pkg::OP_BLUE:  res_b_q <= res_val;
        default:            res_a_q <= res_val;
      endcase
    end
    if (load_out) begin
      out_row_o    <= orow_q;
      out_column_o <= bfid_pkg::OUT_POS_W'(ocol_q);
      out_red_o    <= res_r_q;
      out_green_o  <= res_g_q;
      out_blue_o   <= res_b_q;
      out_alpha_o  <= res_a_q;
      image_done_o <= odone_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The read data is used in the cycle after the accepting read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfid_pkg::S_ACC |-> $past(state_q) == bfid_pkg::S_IDLE)
    else $error("read-modify-write without a preceding read");

  // The sum memory is never written while a pixel read may be in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfid_pkg::S_IDLE |-> !mem_we)
    else $error("sum memory written while idle");

  // The shared divider only finishes while the result is being formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == bfid_pkg::S_DIV && run_q)
    else $error("output divider finished outside the division phase");

  // A result is only loaded after all four channel results are in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> op_q == bfid_pkg::OP_RED && !run_q)
    else $error("result loaded with divisions pending");

endmodule

>>> rtl/bfid_mem.sv
module bfid_mem #(
  parameter int DEPTH = bfid_pkg::MAX_DEST_WIDTH_DEF,
  parameter int AW    = 10
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  bfid_pkg::acc_t wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output bfid_pkg::acc_t rdata_o
);

  bfid_pkg::acc_t mem [DEPTH];
  bfid_pkg::acc_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bfid_div.sv
module bfid_div #(
  parameter int N_W = 40,
  parameter int D_W = 32,
  parameter int Q_W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [Q_W-1:0] quotient_o,
  output logic [D_W-1:0] remainder_o
);

  localparam int W  = D_W + Q_W;
  localparam int CW = $clog2(Q_W + 1);

  logic [W-1:0]   rem_q, rem_d, ds_q, ds_d;
  logic [Q_W-1:0] q_q, q_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           done_q, done_d;
  logic           ge;

  always_comb begin
    rem_d  = rem_q;
    ds_d   = ds_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    ge     = (rem_q >= ds_q);
    if (start_i) begin
      rem_d = W'(dividend_i);
      ds_d  = W'(divisor_i) << (Q_W - 1);
      q_d   = '0;
      cnt_d = CW'(Q_W);
    end else if (cnt_q != '0) begin
      if (ge) begin
        rem_d = rem_q - ds_q;
      end
      q_d    = Q_W'({q_q, ge});
      ds_d   = ds_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    ds_q  <= ds_d;
    q_q   <= q_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = q_q;
  assign remainder_o = rem_q[D_W-1:0];

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf = 6;
  localparam int CycleLimit = 2_000_000;
  localparam int SettleCycles = 80;
  localparam int RandomItems = 800;

  typedef struct {
    logic [9:0] row;
    logic [9:0] column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       done;
  } block_avg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bfid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bfid_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic pix_valid = 1'b0;
  logic pix_ready;
  logic [7:0] pix_red = '0;
  logic [7:0] pix_green = '0;
  logic [7:0] pix_blue = '0;
  logic [7:0] pix_alpha = '0;
  logic avg_valid;
  logic avg_ready = 1'b0;
  logic [9:0] avg_row;
  logic [9:0] avg_column;
  logic [7:0] avg_red;
  logic [7:0] avg_green;
  logic [7:0] avg_blue;
  logic [7:0] avg_alpha;
  logic avg_done;

  box_filter_image_downscaler_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (pix_valid),
    .in_ready_o  (pix_ready),
    .in_red_i    (pix_red),
    .in_green_i  (pix_green),
    .in_blue_i   (pix_blue),
    .in_alpha_i  (pix_alpha),
    .out_valid_o (avg_valid),
    .out_ready_i (avg_ready),
    .out_row_o   (avg_row),
    .out_column_o(avg_column),
    .out_red_o   (avg_red),
    .out_green_o (avg_green),
    .out_blue_o  (avg_blue),
    .out_alpha_o (avg_alpha),
    .image_done_o(avg_done)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Shadow copy of the downscaler state.
  int unsigned reg_src_w = 1, reg_src_h = 1, reg_dst_w = 1, reg_dst_h = 1;
  bit reg_alpha_en = 1'b0;
  logic [39:0] red_acc[1024];
  logic [39:0] green_acc[1024];
  logic [39:0] blue_acc[1024];
  logic [31:0] alpha_acc[1024];
  logic [24:0] count_acc[1024];
  int unsigned src_row, src_col, col_end, row_end, dst_col, dst_row;
  int col_frac, row_frac;

  block_avg_t pending_avgs[$];
  int errors = 0;
  int pixels_sent = 0;
  int cycle = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void scaled_dims(output int unsigned sw, sh, dw, dh);
    sw = clamp_dim(reg_src_w, 4096);
    sh = clamp_dim(reg_src_h, 4096);
    dw = clamp_dim(reg_dst_w, 1024);
    dh = clamp_dim(reg_dst_h, 1024);
    if (dw > sw) dw = sw;
    if (dh > sh) dh = sh;
  endfunction

  function automatic int unsigned step_edge(int unsigned start, int unsigned s,
                                            int unsigned d, ref int frac);
    int unsigned edge_pos;
    edge_pos = start + s / d;
    frac += int'(s % d);
    if (frac > 0) begin
      edge_pos++;
      frac -= int'(d);
    end
    return edge_pos;
  endfunction

  function automatic void restart_image();
    int unsigned sw, sh, dw, dh;
    scaled_dims(sw, sh, dw, dh);
    for (int i = 0; i < 1024; i++) begin
      red_acc[i] = '0;
      green_acc[i] = '0;
      blue_acc[i] = '0;
      alpha_acc[i] = '0;
      count_acc[i] = '0;
    end
    src_row = 0;
    src_col = 0;
    col_end = 0;
    row_end = 0;
    dst_col = 0;
    dst_row = 0;
    col_frac = -int'(dw / 2);
    row_frac = -int'(dh / 2);
  endfunction

  function automatic void accumulate_pixel(logic [7:0] r, g, b, a);
    int unsigned sw, sh, dw, dh, idx;
    logic [39:0] as40, n40;
    block_avg_t res;
    scaled_dims(sw, sh, dw, dh);
    if (src_col >= sw || src_row >= sh) begin
      src_col = 0;
      src_row = 0;
    end
    if (src_col == 0) begin
      if (src_row == 0) begin
        dst_row = 0;
        row_frac = -int'(dh / 2);
        row_end = step_edge(0, sh, dh, row_frac);
      end else if (src_row == row_end) begin
        dst_row++;
        row_end = step_edge(row_end, sh, dh, row_frac);
      end
      dst_col = 0;
      col_frac = -int'(dw / 2);
      col_end = step_edge(0, sw, dw, col_frac);
    end else if (src_col == col_end) begin
      dst_col++;
      col_end = step_edge(col_end, sw, dw, col_frac);
    end
    idx = (dst_col < 1024) ? dst_col : 1023;
    if (reg_alpha_en) begin
      red_acc[idx] += 40'(a) * 40'(r);
      green_acc[idx] += 40'(a) * 40'(g);
      blue_acc[idx] += 40'(a) * 40'(b);
      alpha_acc[idx] += 32'(a);
    end else begin
      red_acc[idx] += 40'(r);
      green_acc[idx] += 40'(g);
      blue_acc[idx] += 40'(b);
    end
    count_acc[idx] += 25'd1;
    if (src_col + 1 == col_end && src_row + 1 == row_end) begin
      n40 = (count_acc[idx] != 0) ? 40'(count_acc[idx]) : 40'd1;
      as40 = 40'(alpha_acc[idx]);
      if (reg_alpha_en) begin
        if (as40 != 0) begin
          res.red = 8'(red_acc[idx] / as40);
          res.green = 8'(green_acc[idx] / as40);
          res.blue = 8'(blue_acc[idx] / as40);
          res.alpha = 8'(as40 / n40);
        end else begin
          res.red = '0;
          res.green = '0;
          res.blue = '0;
          res.alpha = '0;
        end
      end else begin
        res.red = 8'(red_acc[idx] / n40);
        res.green = 8'(green_acc[idx] / n40);
        res.blue = 8'(blue_acc[idx] / n40);
        res.alpha = bfid_pkg::OPAQUE;
      end
      res.row = 10'(dst_row);
      res.column = 10'(dst_col);
      res.done = (dst_row + 1 == dh && dst_col + 1 == dw);
      pending_avgs.push_back(res);
      red_acc[idx] = '0;
      green_acc[idx] = '0;
      blue_acc[idx] = '0;
      alpha_acc[idx] = '0;
      count_acc[idx] = '0;
    end
    src_col++;
    if (src_col >= sw) begin
      src_col = 0;
      src_row++;
      if (src_row >= sh) src_row = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    block_avg_t want;
    if (avg_valid && avg_ready) begin
      if (pending_avgs.size() == 0) begin
        report_mismatch("unexpected result transaction, row", int'(avg_row), -1);
      end else begin
        want = pending_avgs.pop_front();
        if (avg_row !== want.row) report_mismatch("row", avg_row, want.row);
        if (avg_column !== want.column) report_mismatch("column", avg_column, want.column);
        if (avg_red !== want.red) report_mismatch("red", avg_red, want.red);
        if (avg_green !== want.green) report_mismatch("green", avg_green, want.green);
        if (avg_blue !== want.blue) report_mismatch("blue", avg_blue, want.blue);
        if (avg_alpha !== want.alpha) report_mismatch("alpha", avg_alpha, want.alpha);
        if (avg_done !== want.done) report_mismatch("image_done", avg_done, want.done);
      end
    end
  end

  // Receiver stalls with a duty cycle that is redrawn at random from 0, 20, 60 or 90 percent.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 20;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    avg_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    if (cycle > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic pause_input(int n);
    pix_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] r, g, b, a);
    pix_valid <= 1'b1;
    pix_red <= r;
    pix_green <= g;
    pix_blue <= b;
    pix_alpha <= a;
    @(negedge clk);
    while (!pix_ready) @(negedge clk);
    @(posedge clk);
    accumulate_pixel(r, g, b, a);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    pause_input(1);
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(bfid_pkg::cfg_idx_e idx, int unsigned value);
    logic [bfid_pkg::CFG_DATA_W-1:0] v;
    v = bfid_pkg::CFG_DATA_W'(value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      bfid_pkg::CFG_SRC_WIDTH:  reg_src_w = v;
      bfid_pkg::CFG_SRC_HEIGHT: reg_src_h = v;
      bfid_pkg::CFG_DST_WIDTH:  reg_dst_w = v & 11'h7FF;
      bfid_pkg::CFG_DST_HEIGHT: reg_dst_h = v & 11'h7FF;
      default:                  reg_alpha_en = v[0];
    endcase
    restart_image();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_format(int unsigned sw, sh, dw, dh, bit alpha_en);
    write_reg(bfid_pkg::CFG_SRC_WIDTH, sw);
    write_reg(bfid_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(bfid_pkg::CFG_DST_WIDTH, dw);
    write_reg(bfid_pkg::CFG_DST_HEIGHT, dh);
    write_reg(bfid_pkg::CFG_ALPHA_EN, alpha_en);
  endtask

  task automatic send_random_pixel(bit clear_alpha);
    logic [7:0] a;
    a = clear_alpha ? 8'd0 : 8'($urandom);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), a);
  endtask

  task automatic test_directed();
    set_format(2, 2, 1, 1, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h80);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'h01);
    // A fully transparent block must give zeros.
    repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
    wait_drained();
    write_reg(bfid_pkg::CFG_ALPHA_EN, 0);
    send_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
    wait_drained();
    // Zero sizes act as one pixel.
    set_format(0, 0, 0, 0, 1'b0);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    wait_drained();
    // Destination larger than source is held to the source size.
    set_format(3, 2, 2047, 2047, 1'b1);
    repeat (6) send_random_pixel(1'b0);
    wait_drained();
  endtask

  task automatic test_extreme_sizes();
    set_format(8191, 1, 1024, 1, 1'b1);
    repeat (24) send_random_pixel(1'b0);
    wait_drained();
    set_format(1, 8191, 1, 2047, 1'b0);
    repeat (40) send_random_pixel(1'b0);
    wait_drained();
    set_format(1024, 1, 1024, 1, 1'b0);
    repeat (1026) send_random_pixel(1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_format(4, 2, 4, 2, 1'b0);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (12) send_random_pixel(1'b0);
    join
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned sw, sh, dw, dh, n, burst;
    bit transparent;
    int target;
    target = pixels_sent + RandomItems;
    while (pixels_sent < target) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 8);
      dw = $urandom_range(1, sw);
      dh = $urandom_range(1, sh);
      set_format(sw, sh, dw, dh, $urandom_range(0, 1));
      n = sw * sh * $urandom_range(1, 3) + $urandom_range(0, sw * sh - 1);
      if (n > 200) n = 200;
      transparent = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(1, 30);
      repeat (n) begin
        send_random_pixel(transparent && $urandom_range(0, 1));
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 8));
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    restart_image();
    test_directed();
    test_extreme_sizes();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
